// ===== rtl/flash_eeprom_emulation_log_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the flash EEPROM emulation log unit
// Each macro expands to one labeled concurrent assertion, clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FLASH_EEPROM_EMULATION_LOG_UNIT_ASSERT_SVH
`define FLASH_EEPROM_EMULATION_LOG_UNIT_ASSERT_SVH

// Same-cycle implication
`define FEEL_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define FEEL_ASSERT_NXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/feel_pkg.sv =====
// ----------------------------------------------------------------------------
// feel_pkg
// Shared constants, codes and controller/datapath interface types for the
// flash EEPROM emulation log unit.
// ----------------------------------------------------------------------------
`default_nettype none

package feel_pkg;

    // Geometry
    localparam int CACHE_BYTES      = 60;
    localparam int PAGES_PER_SECTOR = 16;
    localparam int RECORDS_PER_PAGE = 128;

    localparam int CACHE_IDX_W = (CACHE_BYTES > 1) ? $clog2(CACHE_BYTES) : 1;
    localparam int SLOT_CNT_W  = 12;
    localparam int SLOT_W      = 11;

    localparam logic [SLOT_CNT_W-1:0] TOTAL_SLOTS =
        SLOT_CNT_W'(PAGES_PER_SECTOR * RECORDS_PER_PAGE);
    localparam logic [SLOT_CNT_W-1:0] TOTAL_SLOTS_M1 =
        SLOT_CNT_W'(PAGES_PER_SECTOR * RECORDS_PER_PAGE - 1);
    localparam logic [7:0] CACHE_LIMIT = 8'(CACHE_BYTES);
    localparam logic [CACHE_IDX_W-1:0] WALK_LAST = CACHE_IDX_W'(CACHE_BYTES - 1);

    // Erased flash byte
    localparam logic [7:0] ERASED = 8'hFF;

    // Input kinds
    localparam logic [1:0] KIND_READ   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_REPLAY = 2'd2;

    // Result operations
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_WREAD,
        ST_WCHK,
        ST_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        RD_PORT,
        RD_ITEM,
        RD_WALK
    } rd_sel_t;

    typedef enum logic [1:0] {
        SRC_READ,
        SRC_PROG,
        SRC_PEND
    } out_src_t;

    typedef struct packed {
        logic     take_item;
        rd_sel_t  rd_sel;
        logic     cache_wr;
        logic     slot_inc;
        logic     slot_clear;
        logic     replay_set;
        logic     out_load;
        out_src_t out_src;
        logic     out_last;
        logic     pend_erase;
        logic     pend_rec;
        logic     pend_clear;
        logic     walk_clear;
        logic     walk_inc;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       addr_end;
        logic       in_cache;
        logic       same_val;
        logic       slot_free;
        logic       slot_last;
        logic       replay_done;
        logic       walk_hit;
        logic       walk_end;
        logic       out_free;
        logic       pend_valid;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/feel_dp.sv =====
// ----------------------------------------------------------------------------
// feel_dp
// Datapath: item registers, byte cache memory with valid bits, log write
// position, compaction walk index, pending record and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flash_eeprom_emulation_log_unit_assert.svh"

module feel_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [1:0]                      kind,
    input  wire logic [7:0]                      address,
    input  wire logic [7:0]                      value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           op,
    output logic [feel_pkg::SLOT_W-1:0]          slot,
    output logic [7:0]                           address_res,
    output logic [7:0]                           value_res,
    output logic                                 last,
    input  wire feel_pkg::cmd_t                  cmd,
    output feel_pkg::sts_t                       sts
);

    localparam int IW = feel_pkg::CACHE_IDX_W;
    localparam int SW = feel_pkg::SLOT_W;
    localparam int CW = feel_pkg::SLOT_CNT_W;

    // Item registers
    logic [1:0] kind_reg, kind_next;
    logic [7:0] addr_reg, addr_next;
    logic [7:0] val_reg, val_next;

    // Cache storage
    logic [7:0]                      cache_mem [feel_pkg::CACHE_BYTES];
    logic [7:0]                      rd_data_reg;
    logic [IW-1:0]                   rd_idx;
    logic [feel_pkg::CACHE_BYTES-1:0] valid_reg, valid_next;

    // Log state
    logic [CW-1:0] next_slot_reg, next_slot_next;
    logic          replay_done_reg, replay_done_next;
    logic [IW-1:0] walk_reg, walk_next;

    // Pending record
    logic          pend_valid_reg, pend_valid_next;
    logic [1:0]    pend_op_reg, pend_op_next;
    logic [SW-1:0] pend_slot_reg, pend_slot_next;
    logic [7:0]    pend_addr_reg, pend_addr_next;
    logic [7:0]    pend_val_reg, pend_val_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_op_reg, out_op_next;
    logic [SW-1:0] out_slot_reg, out_slot_next;
    logic [7:0]    out_addr_reg, out_addr_next;
    logic [7:0]    out_val_reg, out_val_next;
    logic          out_last_reg, out_last_next;

    logic [IW-1:0] item_idx;
    logic          in_cache;
    logic [7:0]    item_byte;
    logic [7:0]    walk_byte;
    logic          out_free;

    // Decode the latched item against the cache
    assign item_idx  = addr_reg[IW-1:0];
    assign in_cache  = addr_reg < feel_pkg::CACHE_LIMIT;
    assign item_byte = (in_cache && valid_reg[item_idx]) ? rd_data_reg : feel_pkg::ERASED;
    assign walk_byte = valid_reg[walk_reg] ? rd_data_reg : feel_pkg::ERASED;
    assign out_free  = !out_valid_reg || out_ready;

    // Select the cache read address
    always_comb
    begin
        unique case (cmd.rd_sel)
            feel_pkg::RD_PORT: rd_idx = address[IW-1:0];
            feel_pkg::RD_ITEM: rd_idx = item_idx;
            feel_pkg::RD_WALK: rd_idx = walk_reg;
            default:           rd_idx = item_idx;
        endcase
    end

    // Write and read the cache memory
    always_ff @(posedge clk)
    begin
        if (cmd.cache_wr)
        begin
            cache_mem[item_idx] <= val_reg;
        end
        rd_data_reg <= cache_mem[rd_idx];
    end

    // Capture the accepted word
    always_comb
    begin
        kind_next = kind_reg;
        addr_next = addr_reg;
        val_next  = val_reg;
        if (cmd.take_item)
        begin
            kind_next = kind;
            addr_next = address;
            val_next  = value;
        end
    end

    // Update valid bits, log position, replay flag and walk index
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.cache_wr)
        begin
            valid_next[item_idx] = 1'b1;
        end

        priority if (cmd.slot_clear)
        begin
            next_slot_next = '0;
        end
        else if (cmd.slot_inc)
        begin
            next_slot_next = next_slot_reg + 1'b1;
        end
        else
        begin
            next_slot_next = next_slot_reg;
        end

        replay_done_next = replay_done_reg | cmd.replay_set;

        priority if (cmd.walk_clear)
        begin
            walk_next = '0;
        end
        else if (cmd.walk_inc)
        begin
            walk_next = walk_reg + 1'b1;
        end
        else
        begin
            walk_next = walk_reg;
        end
    end

    // Hold the pending record until its successor shows whether it is last
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_op_next    = pend_op_reg;
        pend_slot_next  = pend_slot_reg;
        pend_addr_next  = pend_addr_reg;
        pend_val_next   = pend_val_reg;
        if (cmd.pend_clear)
        begin
            pend_valid_next = 1'b0;
        end
        if (cmd.pend_erase)
        begin
            pend_valid_next = 1'b1;
            pend_op_next    = feel_pkg::OP_ERASE;
            pend_slot_next  = '0;
            pend_addr_next  = '0;
            pend_val_next   = '0;
        end
        if (cmd.pend_rec)
        begin
            pend_valid_next = 1'b1;
            pend_op_next    = feel_pkg::OP_PROG;
            pend_slot_next  = next_slot_reg[SW-1:0];
            pend_addr_next  = 8'(walk_reg);
            pend_val_next   = walk_byte;
        end
    end

    // Load or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_op_next    = out_op_reg;
        out_slot_next  = out_slot_reg;
        out_addr_next  = out_addr_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = cmd.out_last;
            unique case (cmd.out_src)
                feel_pkg::SRC_READ:
                begin
                    out_op_next   = feel_pkg::OP_READ;
                    out_slot_next = '0;
                    out_addr_next = '0;
                    out_val_next  = item_byte;
                end
                feel_pkg::SRC_PROG:
                begin
                    out_op_next   = feel_pkg::OP_PROG;
                    out_slot_next = next_slot_reg[SW-1:0];
                    out_addr_next = addr_reg;
                    out_val_next  = val_reg;
                end
                feel_pkg::SRC_PEND:
                begin
                    out_op_next   = pend_op_reg;
                    out_slot_next = pend_slot_reg;
                    out_addr_next = pend_addr_reg;
                    out_val_next  = pend_val_reg;
                end
                default:
                begin
                    out_op_next   = pend_op_reg;
                    out_slot_next = pend_slot_reg;
                    out_addr_next = pend_addr_reg;
                    out_val_next  = pend_val_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            next_slot_reg   <= '0;
            replay_done_reg <= 1'b0;
            walk_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            next_slot_reg   <= next_slot_next;
            replay_done_reg <= replay_done_next;
            walk_reg        <= walk_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        addr_reg      <= addr_next;
        val_reg       <= val_next;
        pend_op_reg   <= pend_op_next;
        pend_slot_reg <= pend_slot_next;
        pend_addr_reg <= pend_addr_next;
        pend_val_reg  <= pend_val_next;
        out_op_reg    <= out_op_next;
        out_slot_reg  <= out_slot_next;
        out_addr_reg  <= out_addr_next;
        out_val_reg   <= out_val_next;
        out_last_reg  <= out_last_next;
    end

    // Status to the controller
    always_comb
    begin
        sts.kind        = kind_reg;
        sts.addr_end    = addr_reg == feel_pkg::ERASED;
        sts.in_cache    = in_cache;
        sts.same_val    = item_byte == val_reg;
        sts.slot_free   = next_slot_reg < feel_pkg::TOTAL_SLOTS;
        sts.slot_last   = next_slot_reg == feel_pkg::TOTAL_SLOTS_M1;
        sts.replay_done = replay_done_reg;
        sts.walk_hit    = walk_byte != feel_pkg::ERASED;
        sts.walk_end    = walk_reg == feel_pkg::WALK_LAST;
        sts.out_free    = out_free;
        sts.pend_valid  = pend_valid_reg;
    end

    assign out_valid   = out_valid_reg;
    assign op          = out_op_reg;
    assign slot        = out_slot_reg;
    assign address_res = out_addr_reg;
    assign value_res   = out_val_reg;
    assign last        = out_last_reg;

    `FEEL_ASSERT_IMP(a_load_needs_room, clk, rst_n, cmd.out_load, out_free,
        "output register loaded while a word is still held")
    `FEEL_ASSERT_IMP(a_pend_not_lost, clk, rst_n, cmd.pend_rec && pend_valid_reg,
        cmd.out_load && (cmd.out_src == feel_pkg::SRC_PEND),
        "pending record overwritten before it was sent")
    `FEEL_ASSERT_IMP(a_cache_wr_in_range, clk, rst_n, cmd.cache_wr, in_cache,
        "cache write to an address outside the cache")
    `FEEL_ASSERT_NXT(a_slot_bound, clk, rst_n, cmd.slot_inc && !cmd.slot_clear,
        next_slot_reg <= feel_pkg::TOTAL_SLOTS,
        "log position ran past the end of the sector")

endmodule

`default_nettype wire

// ===== rtl/feel_ctrl.sv =====
// ----------------------------------------------------------------------------
// feel_ctrl
// Controller: takes one word at a time, decides read, write and replay
// actions, and sequences the erase and compaction walk.
// ----------------------------------------------------------------------------
`default_nettype none

module feel_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire feel_pkg::sts_t sts,
    output feel_pkg::cmd_t      cmd
);

    feel_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= feel_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.rd_sel  = feel_pkg::RD_ITEM;
        cmd.out_src = feel_pkg::SRC_READ;

        unique case (state_reg)
            feel_pkg::ST_IDLE:
            begin
                // Read the cache at the incoming address
                in_ready   = 1'b1;
                cmd.rd_sel = feel_pkg::RD_PORT;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = feel_pkg::ST_LOOK;
                end
            end

            feel_pkg::ST_LOOK:
            begin
                unique case (sts.kind)
                    feel_pkg::KIND_REPLAY:
                    begin
                        if (!sts.replay_done)
                        begin
                            if (sts.addr_end)
                            begin
                                cmd.replay_set = 1'b1;
                            end
                            else
                            begin
                                cmd.cache_wr   = sts.in_cache;
                                cmd.slot_inc   = sts.slot_free;
                                cmd.replay_set = !sts.slot_free || sts.slot_last;
                            end
                        end
                        state_next = feel_pkg::ST_IDLE;
                    end

                    feel_pkg::KIND_READ:
                    begin
                        if (sts.out_free)
                        begin
                            cmd.replay_set = 1'b1;
                            cmd.out_load   = 1'b1;
                            cmd.out_src    = feel_pkg::SRC_READ;
                            cmd.out_last   = 1'b1;
                            state_next     = feel_pkg::ST_IDLE;
                        end
                    end

                    feel_pkg::KIND_WRITE:
                    begin
                        if (!sts.in_cache || sts.same_val)
                        begin
                            // Drop a write outside the cache or one that changes nothing
                            cmd.replay_set = 1'b1;
                            state_next     = feel_pkg::ST_IDLE;
                        end
                        else if (sts.slot_free)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.replay_set = 1'b1;
                                cmd.cache_wr   = 1'b1;
                                cmd.out_load   = 1'b1;
                                cmd.out_src    = feel_pkg::SRC_PROG;
                                cmd.out_last   = !sts.slot_last;
                                cmd.slot_inc   = 1'b1;
                                if (sts.slot_last)
                                begin
                                    cmd.pend_erase = 1'b1;
                                    cmd.slot_clear = 1'b1;
                                    cmd.walk_clear = 1'b1;
                                    state_next     = feel_pkg::ST_WREAD;
                                end
                                else
                                begin
                                    state_next = feel_pkg::ST_IDLE;
                                end
                            end
                        end
                        else
                        begin
                            // Sector already full: cache the byte, then compact
                            cmd.replay_set = 1'b1;
                            cmd.cache_wr   = 1'b1;
                            cmd.pend_erase = 1'b1;
                            cmd.slot_clear = 1'b1;
                            cmd.walk_clear = 1'b1;
                            state_next     = feel_pkg::ST_WREAD;
                        end
                    end

                    default:
                    begin
                        state_next = feel_pkg::ST_IDLE;
                    end
                endcase
            end

            feel_pkg::ST_WREAD:
            begin
                cmd.rd_sel = feel_pkg::RD_WALK;
                state_next = feel_pkg::ST_WCHK;
            end

            feel_pkg::ST_WCHK:
            begin
                cmd.rd_sel = feel_pkg::RD_WALK;
                if (sts.walk_hit && sts.slot_free && sts.pend_valid && !sts.out_free)
                begin
                    // Hold until the pending record can move out
                    state_next = feel_pkg::ST_WCHK;
                end
                else
                begin
                    if (sts.walk_hit && sts.slot_free)
                    begin
                        cmd.out_load = sts.pend_valid;
                        cmd.out_src  = feel_pkg::SRC_PEND;
                        cmd.out_last = 1'b0;
                        cmd.pend_rec = 1'b1;
                        cmd.slot_inc = 1'b1;
                    end
                    if (sts.walk_end)
                    begin
                        state_next = feel_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        cmd.walk_inc = 1'b1;
                        state_next   = feel_pkg::ST_WREAD;
                    end
                end
            end

            feel_pkg::ST_FLUSH:
            begin
                // Send the final record of the compaction
                if (sts.out_free)
                begin
                    cmd.out_load   = sts.pend_valid;
                    cmd.out_src    = feel_pkg::SRC_PEND;
                    cmd.out_last   = 1'b1;
                    cmd.pend_clear = 1'b1;
                    state_next     = feel_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = feel_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/flash_eeprom_emulation_log_unit.sv =====
// ----------------------------------------------------------------------------
// flash_eeprom_emulation_log_unit: byte EEPROM emulated on a flash record log
// Each word is taken in IDLE and handled in LOOK; the cache memory is read as
// the word is accepted, and a read result enters the output register when free.
// A write that fills the sector adds erase and compaction: each cache byte is
// read in WREAD and checked in WCHK, where output stalls hold it; FLUSH ends it.
// Reset: cache reads 0xFF at once through valid bits; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_eeprom_emulation_log_unit (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [1:0]             kind,
    input  wire logic [7:0]             address,
    input  wire logic [7:0]             value,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [1:0]                  op,
    output logic [feel_pkg::SLOT_W-1:0] slot,
    output logic [7:0]                  address_res,
    output logic [7:0]                  value_res,
    output logic                        last
);

    feel_pkg::cmd_t cmd;
    feel_pkg::sts_t sts;

    // Sequence each word
    feel_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Cache, log position and result registers
    feel_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (kind),
        .address     (address),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .op          (op),
        .slot        (slot),
        .address_res (address_res),
        .value_res   (value_res),
        .last        (last),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: flash EEPROM emulation log unit
// Replays a short record log into the block, then drives reads and writes and
// checks every flash command it emits against a shadow copy of the byte cache
// and the log write position. The replay either stops at the end mark or is
// closed by the first access.
// ----------------------------------------------------------------------------

module tb;

    import feel_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         LONG_HOLD   = 300;
    localparam int         RANDOM_WORDS = 80;
    localparam int         TAIL_WORDS   = 20;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        addr;
        logic [7:0]        data;
        logic              last;
    } flash_cmd_t;

    // Shadow of the cache and log position; holds the flash commands still due
    class eeprom_shadow;
        logic [7:0]            byte_copy [CACHE_BYTES];
        logic [SLOT_CNT_W-1:0] log_fill;
        bit                    replay_closed;
        flash_cmd_t            cmds_due [$];
        int                    failures;
        int                    words_taken;
        int                    replays_taken;
        int                    reads_seen;
        int                    progs_seen;
        int                    erases_seen;

        function new();
            foreach (byte_copy[i])
                byte_copy[i] = ERASED;
            log_fill      = '0;
            replay_closed = 1'b0;
        endfunction

        function flash_cmd_t make_cmd(logic [1:0] o, logic [SLOT_W-1:0] s,
                                      logic [7:0] a, logic [7:0] d);
            flash_cmd_t c;
            c.op   = o;
            c.slot = s;
            c.addr = a;
            c.data = d;
            c.last = 1'b0;
            return c;
        endfunction

        // Advance the shadow by one accepted word and queue its commands
        function void apply_word(logic [1:0] k, logic [7:0] a, logic [7:0] v);
            flash_cmd_t batch [$];
            words_taken++;
            if (k == KIND_REPLAY)
            begin
                replays_taken++;
                if (replay_closed)
                    return;
                if (a == ERASED)
                begin
                    replay_closed = 1'b1;
                    return;
                end
                if (a < CACHE_LIMIT)
                    byte_copy[a] = v;
                if (log_fill < TOTAL_SLOTS)
                    log_fill++;
                if (log_fill >= TOTAL_SLOTS)
                    replay_closed = 1'b1;
                return;
            end
            if (k == KIND_UNUSED)
                return;

            // any access closes the replay
            replay_closed = 1'b1;
            if (k == KIND_READ)
            begin
                batch.push_back(make_cmd(OP_READ, '0, '0,
                                         (a < CACHE_LIMIT) ? byte_copy[a] : ERASED));
            end
            else if (a < CACHE_LIMIT && byte_copy[a] != v)
            begin
                byte_copy[a] = v;
                if (log_fill < TOTAL_SLOTS)
                begin
                    batch.push_back(make_cmd(OP_PROG, log_fill[SLOT_W-1:0], a, v));
                    log_fill++;
                end
                // sector full: erase, then rewrite live bytes from slot 0
                if (log_fill >= TOTAL_SLOTS)
                begin
                    batch.push_back(make_cmd(OP_ERASE, '0, '0, '0));
                    log_fill = '0;
                    for (int i = 0; i < CACHE_BYTES; i++)
                    begin
                        if (byte_copy[i] != ERASED && log_fill < TOTAL_SLOTS)
                        begin
                            batch.push_back(make_cmd(OP_PROG, log_fill[SLOT_W-1:0],
                                                     8'(i), byte_copy[i]));
                            log_fill++;
                        end
                    end
                end
            end
            if (batch.size() > 0)
                batch[batch.size()-1].last = 1'b1;
            foreach (batch[i])
                cmds_due.push_back(batch[i]);
        endfunction

        // Compare one emitted command with the oldest one due
        function void match_command(logic [1:0] g_op, logic [SLOT_W-1:0] g_slot,
                                    logic [7:0] g_addr, logic [7:0] g_val,
                                    logic g_last);
            flash_cmd_t want;
            if (cmds_due.size() == 0)
            begin
                $error("unexpected command: op %0d slot %0d address_res %0d value_res %0d",
                       g_op, g_slot, g_addr, g_val);
                failures++;
                return;
            end
            want = cmds_due.pop_front();
            if (want.op == OP_READ)
                reads_seen++;
            else if (want.op == OP_PROG)
                progs_seen++;
            else
                erases_seen++;
            if (g_op !== want.op)
            begin
                $error("op: expected %0d, actual %0d", want.op, g_op);
                failures++;
            end
            if (g_slot !== want.slot)
            begin
                $error("slot: expected %0d, actual %0d", want.slot, g_slot);
                failures++;
            end
            if (g_addr !== want.addr)
            begin
                $error("address_res: expected %0d, actual %0d", want.addr, g_addr);
                failures++;
            end
            if (g_val !== want.data)
            begin
                $error("value_res: expected %0d, actual %0d", want.data, g_val);
                failures++;
            end
            if (g_last !== want.last)
            begin
                $error("last: expected %0d, actual %0d", want.last, g_last);
                failures++;
            end
        endfunction
    endclass

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic [1:0]        kind      = KIND_READ;
    logic [7:0]        address   = '0;
    logic [7:0]        value     = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        address_res;
    logic [7:0]        value_res;
    logic              last;

    bit                steady    = 1'b0;
    bit                hold_req  = 1'b0;
    eeprom_shadow      shadow    = new();

    flash_eeprom_emulation_log_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .address     (address),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .op          (op),
        .slot        (slot),
        .address_res (address_res),
        .value_res   (value_res),
        .last        (last)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Offer one word from a falling edge, hold it until taken, return at a falling edge
    task automatic send_word(input logic [1:0] k, input logic [7:0] a, input logic [7:0] v);
        if (!steady && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        address  <= a;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        shadow.apply_word(k, a, v);
        @(negedge clk);
    endtask

    // Mostly reads and writes into the cache, with some noise
    task automatic random_word();
        int         pick;
        logic [7:0] a;
        logic [7:0] v;
        pick = $urandom_range(0, 99);
        a = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, CACHE_BYTES - 1));
        v = 8'($urandom_range(0, 255));
        if (pick < 40)
            send_word(KIND_READ, a, v);
        else if (pick < 90)
        begin
            // now and then rewrite the value already held
            if ($urandom_range(0, 7) == 0 && a < CACHE_LIMIT)
                v = shadow.byte_copy[a];
            send_word(KIND_WRITE, a, v);
        end
        else if (pick < 95)
            send_word(KIND_REPLAY, a, v);
        else
            send_word(KIND_UNUSED, a, v);
    endtask

    // Accept results, check at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.match_command(op, slot, address_res, value_res, last);
    end

    // Receiver: random stalls, one long hold-off when asked
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat (steady ? 1 : $urandom_range(1, 20)) @(negedge clk);
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int         mode;
        int         records;
        logic [7:0] a;
        string      replay_end;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rebuild from a short log: stop at the end mark, or run into an access
        mode = $urandom_range(0, 1);
        records = $urandom_range(4, 16);
        for (int n = 0; n < records; n++)
        begin
            a = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(CACHE_BYTES, 254))
                                            : 8'($urandom_range(0, CACHE_BYTES - 1));
            send_word(KIND_REPLAY, a, 8'($urandom_range(0, 255)));
        end
        if (mode == 0)
        begin
            replay_end = "the end mark";
            send_word(KIND_REPLAY, ERASED, 8'h81);
        end
        else
            replay_end = "the first access";

        // Directed: cache edges, out-of-cache addresses, ignored words, no-op writes
        send_word(KIND_UNUSED, 8'hFF, 8'hFF);
        send_word(KIND_READ, 8'd0, 8'h00);
        send_word(KIND_READ, 8'(CACHE_BYTES - 1), 8'hFF);
        send_word(KIND_READ, CACHE_LIMIT, 8'h00);
        send_word(KIND_READ, 8'hFF, 8'h00);
        send_word(KIND_REPLAY, 8'd5, 8'h12);
        send_word(KIND_REPLAY, ERASED, 8'h00);
        send_word(KIND_WRITE, 8'd0, 8'h00);
        send_word(KIND_WRITE, 8'(CACHE_BYTES - 1), 8'hFF);
        send_word(KIND_WRITE, 8'd0, 8'h00);
        send_word(KIND_WRITE, CACHE_LIMIT, 8'hAA);
        send_word(KIND_WRITE, 8'hFF, 8'h55);
        send_word(KIND_WRITE, 8'd1, 8'hA5);
        send_word(KIND_WRITE, 8'd2, 8'h5A);
        send_word(KIND_READ, 8'd0, 8'h00);
        send_word(KIND_READ, 8'd1, 8'h00);
        send_word(KIND_READ, 8'd5, 8'h00);
        send_word(KIND_READ, 8'(CACHE_BYTES - 1), 8'h00);
        send_word(KIND_UNUSED, 8'h00, 8'h00);

        // Random mix; partway, the receiver holds off so the block backs up
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 30)
                hold_req = 1'b1;
            random_word();
        end

        // Back-to-back tail with no stalls on either side
        steady = 1'b1;
        for (int n = 0; n < TAIL_WORDS; n++)
            random_word();
        in_valid <= 1'b0;

        // Drain, then give a compaction's worth of cycles for stray output
        while (shadow.cmds_due.size() != 0)
            @(posedge clk);
        repeat (2 * CACHE_BYTES + 8) @(posedge clk);

        $display("Sent %0d words, %0d of them replays; replay closed by %s.",
                 shadow.words_taken, shadow.replays_taken, replay_end);
        $display("Checked %0d reads, %0d record programs and %0d sector erases.",
                 shadow.reads_seen, shadow.progs_seen, shadow.erases_seen);
        if (shadow.failures == 0 && shadow.cmds_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== flash_eeprom_emulation_log_unit.f =====
+incdir+rtl
rtl/feel_pkg.sv
rtl/feel_dp.sv
rtl/feel_ctrl.sv
rtl/flash_eeprom_emulation_log_unit.sv
tb/tb.sv
